>>> hw/rtl/line_rasterizer_dda_assert.svh
// assertion macros used by the line rasterizer top level
`ifndef LINE_RASTERIZER_DDA_ASSERT_SVH
`define LINE_RASTERIZER_DDA_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define LRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define LRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer assertion failed");

`endif

>>> hw/rtl/lrd_pkg.sv
// package with widths, fixed-point constants and types of the line rasterizer
`timescale 1ns / 1ps

package lrd_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int COLOR_BITS = 32;

    // slope is unsigned Q1.FRAC_BITS, deviation is signed Q2.FRAC_BITS
    localparam int SLOPE_BITS = FRAC_BITS + 1;
    localparam int DEV_BITS   = FRAC_BITS + 3;

    // dividend is (num << (FRAC_BITS + 1)) + den
    localparam int DIV_W     = COORD_BITS + FRAC_BITS + 2;
    localparam int DIV_STEPS = DIV_W;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [SLOPE_BITS-1:0]      slope_t;
    typedef logic signed [DEV_BITS-1:0] dev_t;
    typedef logic [COLOR_BITS-1:0]      color_t;

    localparam dev_t DEV_ONE  = dev_t'(1 << FRAC_BITS);
    localparam dev_t DEV_HALF = dev_t'(1 << (FRAC_BITS - 1));

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef struct packed {
        logic   start;
        coord_t num;
        coord_t den;
    } div_req_t;

    typedef struct packed {
        logic   busy;
        logic   done;
        slope_t quotient;
    } div_rsp_t;

endpackage

>>> hw/rtl/lrd_div.sv
// shift-subtract divider that forms the rounded slope one quotient bit per cycle
`timescale 1ns / 1ps

module lrd_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  lrd_pkg::div_req_t req,
    output lrd_pkg::div_rsp_t rsp
);

    logic [lrd_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [lrd_pkg::DIV_W-1:0]      dvd_reg, dvd_next;
    logic [lrd_pkg::SLOPE_BITS-1:0] quo_reg, quo_next;
    logic [lrd_pkg::COORD_BITS:0]   rem_reg, rem_next;
    logic [lrd_pkg::COORD_BITS:0]   dsor_reg, dsor_next;
    logic [lrd_pkg::COORD_BITS+1:0] rem_sh;
    logic [lrd_pkg::COORD_BITS+1:0] dsor_ext;
    logic [lrd_pkg::COORD_BITS:0]   diff;
    logic                           ge;
    logic                           busy;

    assign busy     = (cnt_reg != '0);
    assign rem_sh   = {rem_reg, dvd_reg[lrd_pkg::DIV_W-1]};
    assign dsor_ext = {1'b0, dsor_reg};
    assign ge       = (rem_sh >= dsor_ext);
    // remainder after a subtract is below the divisor, so the low bits suffice
    assign diff     = rem_sh[lrd_pkg::COORD_BITS:0] - dsor_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsor_next = dsor_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // round to nearest: (2 * num * 2^F + den) / (2 * den)
            dvd_next  = {req.num, {(lrd_pkg::FRAC_BITS + 1){1'b0}}, 1'b0} >> 1;
            dvd_next  = dvd_next + lrd_pkg::DIV_W'(req.den);
            dsor_next = {req.den, 1'b0};
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = lrd_pkg::CNT_BITS'(lrd_pkg::DIV_STEPS);
        end
        else if (busy)
        begin
            rem_next  = ge ? diff : rem_sh[lrd_pkg::COORD_BITS:0];
            dvd_next  = {dvd_reg[lrd_pkg::DIV_W-2:0], 1'b0};
            quo_next  = {quo_reg[lrd_pkg::SLOPE_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == lrd_pkg::CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
    end

    // quotient never exceeds 2^F because num <= den, so only the low bits are kept
    assign rsp.busy     = busy;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> hw/rtl/line_rasterizer_dda.sv
// top level of the dda line rasterizer: setup sequencer, pixel stepper, output register
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | req_type, x_start, y_start, x_end, y_end,
//           |           |                       | draw_color
//   out     | output    | out_valid / out_stall | pixel_x, pixel_y, pixel_color, pixel_valid,
//           |           |                       | last_pixel
//
// a start item passes through setup and the shift-subtract divider, which forms the
//   slope one quotient bit per cycle, then waits in emit until the output register is free
// a single-point start (both endpoints equal) skips the divider
// an advance item makes its pixel with one add of slope and deviation
// rst_n clears the sequencer, the line state and the output valid flag at once
// in_stall is high while a start is in setup, division or emit and while a held item waits on out_stall
`timescale 1ns / 1ps
`include "line_rasterizer_dda_assert.svh"

module line_rasterizer_dda
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   req_type,
    input  logic [11:0]            x_start,
    input  logic [11:0]            y_start,
    input  logic [11:0]            x_end,
    input  logic [11:0]            y_end,
    input  logic [31:0]            draw_color,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [11:0]            pixel_x,
    output logic [11:0]            pixel_y,
    output logic [31:0]            pixel_color,
    output logic                   pixel_valid,
    output logic                   last_pixel
);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]              state_reg, state_next;

    // line state
    logic                    active_reg, active_next;
    logic                    swapped_reg, swapped_next;
    logic                    rising_reg, rising_next;
    lrd_pkg::coord_t         major_pos_reg, major_pos_next;
    lrd_pkg::coord_t         major_end_reg, major_end_next;
    lrd_pkg::coord_t         minor_pos_reg, minor_pos_next;
    lrd_pkg::slope_t         slope_reg, slope_next;
    lrd_pkg::dev_t           dev_reg, dev_next;
    lrd_pkg::color_t         color_reg, color_next;

    // captured endpoints of a start item
    lrd_pkg::coord_t         x1_reg, x1_next;
    lrd_pkg::coord_t         y1_reg, y1_next;
    lrd_pkg::coord_t         x2_reg, x2_next;
    lrd_pkg::coord_t         y2_reg, y2_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    lrd_pkg::coord_t         px_reg, px_next;
    lrd_pkg::coord_t         py_reg, py_next;
    lrd_pkg::color_t         pcolor_reg, pcolor_next;
    logic                    pvalid_reg, pvalid_next;
    logic                    plast_reg, plast_next;

    lrd_pkg::div_req_t       div_req;
    lrd_pkg::div_rsp_t       div_rsp;

    logic                    out_free;
    logic                    in_accept;

    // setup datapath
    lrd_pkg::coord_t         w, h;
    logic                    steep;
    lrd_pkg::coord_t         ma_s, ma_e, mi_s, mi_e;
    lrd_pkg::coord_t         num, den;
    logic                    flip;

    // advance datapath
    lrd_pkg::coord_t         maj_inc;
    logic                    minor_step;
    lrd_pkg::coord_t         minor_stepped;
    lrd_pkg::dev_t           slope_ext;
    lrd_pkg::dev_t           dev_adv;
    logic                    adv_last;

    // checker terms
    logic                    slope_in_range;
    logic                    idle_item_zero;
    logic                    adv_ends_line;

    lrd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output register can take a new item when empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;

    // axis selection and endpoint ordering
    always_comb
    begin
        w     = (x2_reg >= x1_reg) ? (x2_reg - x1_reg) : (x1_reg - x2_reg);
        h     = (y2_reg >= y1_reg) ? (y2_reg - y1_reg) : (y1_reg - y2_reg);
        steep = (w < h);
        num   = steep ? w : h;
        den   = steep ? h : w;
        ma_s  = steep ? y1_reg : x1_reg;
        ma_e  = steep ? y2_reg : x2_reg;
        mi_s  = steep ? x1_reg : y1_reg;
        mi_e  = steep ? x2_reg : y2_reg;
        flip  = (ma_e < ma_s);
    end

    // one pixel step: major rises, minor steps once deviation passes one half
    assign slope_ext     = $signed({2'b00, slope_reg});
    assign maj_inc       = major_pos_reg + 1'b1;
    assign minor_step    = (dev_reg > lrd_pkg::DEV_HALF);
    assign minor_stepped = rising_reg ? (minor_pos_reg + 1'b1) : (minor_pos_reg - 1'b1);
    assign dev_adv       = dev_reg - (minor_step ? lrd_pkg::DEV_ONE : '0) + slope_ext;
    assign adv_last      = (maj_inc == major_end_reg);

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        swapped_next   = swapped_reg;
        rising_next    = rising_reg;
        major_pos_next = major_pos_reg;
        major_end_next = major_end_reg;
        minor_pos_next = minor_pos_reg;
        slope_next     = slope_reg;
        dev_next       = dev_reg;
        color_next     = color_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pcolor_next    = pcolor_reg;
        pvalid_next    = pvalid_reg;
        plast_next     = plast_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_req.start  = 1'b0;
        div_req.num    = num;
        div_req.den    = den;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == lrd_pkg::REQ_START)
                    begin
                        // a start abandons any line in progress
                        x1_next    = x_start;
                        y1_next    = y_start;
                        x2_next    = x_end;
                        y2_next    = y_end;
                        color_next = draw_color;
                        state_next = ST_SETUP;
                    end
                    else if (active_reg)
                    begin
                        major_pos_next = maj_inc;
                        if (minor_step)
                        begin
                            minor_pos_next = minor_stepped;
                        end
                        dev_next       = dev_adv;
                        active_next    = !adv_last;
                        px_next        = swapped_reg ? (minor_step ? minor_stepped
                                                                   : minor_pos_reg) : maj_inc;
                        py_next        = swapped_reg ? maj_inc : (minor_step ? minor_stepped
                                                                             : minor_pos_reg);
                        pcolor_next    = color_reg;
                        pvalid_next    = 1'b1;
                        plast_next     = adv_last;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        // advance with no line: all-zero item
                        px_next        = '0;
                        py_next        = '0;
                        pcolor_next    = '0;
                        pvalid_next    = 1'b0;
                        plast_next     = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_SETUP:
            begin
                swapped_next   = steep;
                major_pos_next = flip ? ma_e : ma_s;
                major_end_next = flip ? ma_s : ma_e;
                minor_pos_next = flip ? mi_e : mi_s;
                rising_next    = flip ? (mi_e < mi_s) : (mi_s < mi_e);
                dev_next       = '0;
                if (den == '0)
                begin
                    slope_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    slope_next = div_rsp.quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    px_next        = swapped_reg ? minor_pos_reg : major_pos_reg;
                    py_next        = swapped_reg ? major_pos_reg : minor_pos_reg;
                    pcolor_next    = color_reg;
                    pvalid_next    = 1'b1;
                    plast_next     = (major_pos_reg == major_end_reg);
                    out_valid_next = 1'b1;
                    dev_next       = slope_ext;
                    active_next    = (major_pos_reg != major_end_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            swapped_reg   <= 1'b0;
            rising_reg    <= 1'b0;
            major_pos_reg <= '0;
            major_end_reg <= '0;
            minor_pos_reg <= '0;
            slope_reg     <= '0;
            dev_reg       <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            swapped_reg   <= swapped_next;
            rising_reg    <= rising_next;
            major_pos_reg <= major_pos_next;
            major_end_reg <= major_end_next;
            minor_pos_reg <= minor_pos_next;
            slope_reg     <= slope_next;
            dev_reg       <= dev_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pcolor_reg <= pcolor_next;
        pvalid_reg <= pvalid_next;
        plast_reg  <= plast_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pcolor_reg;
    assign pixel_valid = pvalid_reg;
    assign last_pixel  = plast_reg;

    assign slope_in_range = (slope_reg <= lrd_pkg::SLOPE_BITS'(lrd_pkg::DEV_ONE));
    assign idle_item_zero = (pixel_x == '0) && (pixel_y == '0) && !last_pixel;
    assign adv_ends_line  = in_accept && (req_type == lrd_pkg::REQ_ADVANCE) && active_reg
                            && adv_last;

    // items enter only while the sequencer rests
    `LRD_ASSERT_NOW(a_accept_in_idle, in_valid && !in_stall, state_reg == ST_IDLE)
    // divider runs and finishes only while the sequencer waits on it
    `LRD_ASSERT_NOW(a_div_busy_in_div, div_rsp.busy, state_reg == ST_DIV)
    `LRD_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_reg == ST_DIV)
    // slope stays within one
    `LRD_ASSERT_NOW(a_slope_max_one, state_reg == ST_EMIT, slope_in_range)
    // an idle-advance item carries no coordinates and no end flag
    `LRD_ASSERT_NOW(a_invalid_is_zero, out_valid && !pixel_valid, idle_item_zero)
    // the last pixel ends the line
    `LRD_ASSERT_NEXT(a_last_clears_active, adv_ends_line, !active_reg)

endmodule
